// ----- src/hight_pkg.sv -----
// ----------------------------------------------------------------------------
// hight_pkg
// Shared types, constants and byte functions for the HIGHT block cipher unit.
// ----------------------------------------------------------------------------
package hight_pkg;

  localparam int ROUNDS  = 32;
  localparam int SUBKEYS = 4 * ROUNDS;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } reg_index_t;

  // Control that travels down the pipeline beside each block.
  typedef struct packed {
    logic valid;
    logic dec;
  } stage_ctl_t;

  // Fixed delta constants of the key schedule.
  localparam logic [7:0] DELTA [SUBKEYS] = '{
    8'h5a, 8'h6d, 8'h36, 8'h1b, 8'h0d, 8'h06, 8'h03, 8'h41,
    8'h60, 8'h30, 8'h18, 8'h4c, 8'h66, 8'h33, 8'h59, 8'h2c,
    8'h56, 8'h2b, 8'h15, 8'h4a, 8'h65, 8'h72, 8'h39, 8'h1c,
    8'h4e, 8'h67, 8'h73, 8'h79, 8'h3c, 8'h5e, 8'h6f, 8'h37,
    8'h5b, 8'h2d, 8'h16, 8'h0b, 8'h05, 8'h42, 8'h21, 8'h50,
    8'h28, 8'h54, 8'h2a, 8'h55, 8'h6a, 8'h75, 8'h7a, 8'h7d,
    8'h3e, 8'h5f, 8'h2f, 8'h17, 8'h4b, 8'h25, 8'h52, 8'h29,
    8'h14, 8'h0a, 8'h45, 8'h62, 8'h31, 8'h58, 8'h6c, 8'h76,
    8'h3b, 8'h1d, 8'h0e, 8'h47, 8'h63, 8'h71, 8'h78, 8'h7c,
    8'h7e, 8'h7f, 8'h3f, 8'h1f, 8'h0f, 8'h07, 8'h43, 8'h61,
    8'h70, 8'h38, 8'h5c, 8'h6e, 8'h77, 8'h7b, 8'h3d, 8'h1e,
    8'h4f, 8'h27, 8'h53, 8'h69, 8'h34, 8'h1a, 8'h4d, 8'h26,
    8'h13, 8'h49, 8'h24, 8'h12, 8'h09, 8'h04, 8'h02, 8'h01,
    8'h40, 8'h20, 8'h10, 8'h08, 8'h44, 8'h22, 8'h11, 8'h48,
    8'h64, 8'h32, 8'h19, 8'h0c, 8'h46, 8'h23, 8'h51, 8'h68,
    8'h74, 8'h3a, 8'h5d, 8'h2e, 8'h57, 8'h6b, 8'h35, 8'h5a
  };

  // Master key byte that feeds subkey n.
  function automatic logic [3:0] mk_index(input logic [6:0] n);
    logic [2:0] low;
    low = n[2:0] - n[6:4];
    return {n[3], low};
  endfunction

  function automatic logic [7:0] fn0(input logic [7:0] x);
    return {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[0], x[7:1]};
  endfunction

  function automatic logic [7:0] fn1(input logic [7:0] x);
    return {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]} ^ {x[1:0], x[7:2]};
  endfunction

endpackage

// ----- src/hight_key_sched.sv -----
// ----------------------------------------------------------------------------
// hight_key_sched
// Derives the round subkeys from the master key, four bytes per round.
// ----------------------------------------------------------------------------
module hight_key_sched import hight_pkg::*; (
  input  logic [127:0]                  key,
  output logic [ROUNDS-1:0][31:0]       round_keys
);

  // Every subkey is one master key byte plus its delta constant.
  always_comb begin
    for (int n = 0; n < SUBKEYS; n++) begin
      round_keys[n / 4][8 * (n % 4) +: 8] = key[8 * mk_index(7'(n)) +: 8] + DELTA[n];
    end
  end

endmodule

// ----- src/hight_whiten.sv -----
// ----------------------------------------------------------------------------
// hight_whiten
// Registered whitening stage: add the key bytes on encryption, subtract them
// on decryption, xor on the odd key bytes.
// ----------------------------------------------------------------------------
module hight_whiten import hight_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  stage_ctl_t  ctl_in,
  input  logic [63:0] blk_in,
  input  logic [31:0] wk_enc,
  input  logic [31:0] wk_dec,
  output stage_ctl_t  ctl_out,
  output logic [63:0] blk_out
);

  logic [31:0] wk;
  logic [63:0] blk_next;

  always_comb begin
    wk       = ctl_in.dec ? wk_dec : wk_enc;
    blk_next = blk_in;
    if (ctl_in.dec) begin
      blk_next[7:0]   = blk_in[7:0]   - wk[7:0];
      blk_next[39:32] = blk_in[39:32] - wk[23:16];
    end else begin
      blk_next[7:0]   = blk_in[7:0]   + wk[7:0];
      blk_next[39:32] = blk_in[39:32] + wk[23:16];
    end
    blk_next[23:16] = blk_in[23:16] ^ wk[15:8];
    blk_next[55:48] = blk_in[55:48] ^ wk[31:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.dec <= ctl_in.dec;
    blk_out     <= blk_next;
  end

endmodule

// ----- src/hight_round.sv -----
// ----------------------------------------------------------------------------
// hight_round
// One registered round of the cipher, serving both directions. Encryption
// runs the round then, if rot_enc, rotates left by one byte; decryption
// first rotates right by one byte if rot_dec, then runs the inverse round.
// ----------------------------------------------------------------------------
module hight_round import hight_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  stage_ctl_t  ctl_in,
  input  logic [63:0] blk_in,
  input  logic [31:0] key_enc,
  input  logic [31:0] key_dec,
  input  logic        rot_enc,
  input  logic        rot_dec,
  output stage_ctl_t  ctl_out,
  output logic [63:0] blk_out
);

  logic [63:0] a;
  logic [63:0] b;
  logic [31:0] k;
  logic [7:0]  t1;
  logic [7:0]  t5;
  logic [63:0] blk_next;

  always_comb begin
    a = (ctl_in.dec && rot_dec) ? {blk_in[7:0], blk_in[63:8]} : blk_in;
    k = ctl_in.dec ? key_dec : key_enc;
    t1 = fn1(a[7:0])   ^ k[7:0];
    t5 = fn1(a[39:32]) ^ k[23:16];
    b = a;
    b[15:8]  = ctl_in.dec ? (a[15:8] - t1)  : (a[15:8] + t1);
    b[47:40] = ctl_in.dec ? (a[47:40] - t5) : (a[47:40] + t5);
    b[31:24] = a[31:24] ^ (fn0(a[23:16]) + k[15:8]);
    b[63:56] = a[63:56] ^ (fn0(a[55:48]) + k[31:24]);
    blk_next = (!ctl_in.dec && rot_enc) ? {b[55:0], b[63:56]} : b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.dec <= ctl_in.dec;
    blk_out     <= blk_next;
  end

endmodule

// ----- src/hight_block_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// hight_block_cipher_unit
// HIGHT 64-bit block cipher with a 128-bit key, fully pipelined.
// A block accepted at a clock edge passes through one whitening stage, 32
// round stages and one output whitening stage, and shows on data_out with
// done high. Throughput: one block per cycle while busy is low, set by the
// round-per-stage pipeline. Reset clears both key registers and all valid
// bits; busy is high for the cycle after reset. done cannot be held off.
// ----------------------------------------------------------------------------
module hight_block_cipher_unit import hight_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Block request channel.
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [63:0] data_in,
  // Result channel: one transaction per accepted block, shown for one cycle.
  output logic        done,
  output logic [63:0] data_out,
  // Key register write port.
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [63:0] wr_data
);

  // The key registers. They may only change while no block is in flight, so
  // every stage reads them directly instead of carrying the key along.
  logic [63:0] key_low;
  logic [63:0] key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_KEY_LOW:  key_low  <= wr_data;
        REG_KEY_HIGH: key_high <= wr_data;
        default: ;
      endcase
    end
  end

  // The unit holds off requests only in the cycle right after reset; the
  // pipeline itself never stalls since the receiver cannot push back.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic [ROUNDS-1:0][31:0] round_keys;

  hight_key_sched u_key_sched (
    .key        ({key_high, key_low}),
    .round_keys (round_keys)
  );

  stage_ctl_t in_ctl;
  assign in_ctl.valid = start && !busy && !rst;
  assign in_ctl.dec   = req_type;

  // Pipeline state between stages: entry 0 is the input whitening output,
  // entry s+1 is the output of round stage s.
  stage_ctl_t        stg_ctl [ROUNDS+1];
  logic       [63:0] stg_blk [ROUNDS+1];

  // Input whitening: key bytes 12..15 on encryption, bytes 0..3 on decryption.
  hight_whiten u_whiten_in (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (in_ctl),
    .blk_in  (data_in),
    .wk_enc  (key_high[63:32]),
    .wk_dec  (key_low[31:0]),
    .ctl_out (stg_ctl[0]),
    .blk_out (stg_blk[0])
  );

  // Round stage s uses subkey group s on encryption and group ROUNDS-1-s on
  // decryption, so both directions flow through the same stages. The last
  // encryption round and the first decryption round skip the byte rotation.
  for (genvar s = 0; s < ROUNDS; s++) begin : g_round
    hight_round u_round (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (stg_ctl[s]),
      .blk_in  (stg_blk[s]),
      .key_enc (round_keys[s]),
      .key_dec (round_keys[ROUNDS-1-s]),
      .rot_enc (s != ROUNDS - 1),
      .rot_dec (s != 0),
      .ctl_out (stg_ctl[s+1]),
      .blk_out (stg_blk[s+1])
    );
  end

  // Output whitening doubles as the output register.
  stage_ctl_t out_ctl;

  hight_whiten u_whiten_out (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (stg_ctl[ROUNDS]),
    .blk_in  (stg_blk[ROUNDS]),
    .wk_enc  (key_low[31:0]),
    .wk_dec  (key_high[63:32]),
    .ctl_out (out_ctl),
    .blk_out (data_out)
  );

  assign done = out_ctl.valid;

`ifndef SYNTHESIS
  // Every accepted request produces its result exactly at the pipeline depth.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##34 done)
    else $error("accepted block did not complete after the pipeline depth");

  // No result appears without a request accepted at the pipeline depth before.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, 34))
    else $error("result without a matching accepted request");

  // The request is always taken in the cycles that follow the first one.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy)
    else $error("busy raised outside the cycle after reset");
`endif

endmodule

// ----- tb/sv/hight_block_checker.sv -----
// ----------------------------------------------------------------------------
// hight_block_checker
// Watches the block request, result and key write channels of the HIGHT
// cipher unit, computes the expected output block for each accepted request
// from its own copy of the key registers, and compares results in order.
// ----------------------------------------------------------------------------
module hight_block_checker import hight_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        req_type,
  input  logic [63:0] data_in,
  input  logic        done,
  input  logic [63:0] data_out,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [63:0] wr_data,
  output int          error_count,
  output int          blocks_in_flight
);

  typedef struct {
    logic        dec;
    logic [63:0] block_in;
    logic [63:0] block_out;
  } block_txn_t;

  block_txn_t  expected_blocks [$];
  logic [63:0] key_lo = '0;
  logic [63:0] key_hi = '0;
  logic [7:0]  delta_tab [128];
  int          mismatches = 0;

  // The delta constants come from a 7-bit LFSR seeded with 0x5a.
  initial begin : build_delta
    logic [6:0] s;
    s = 7'h5a;
    for (int n = 0; n < 128; n++) begin
      delta_tab[n] = {1'b0, s};
      s = {s[3] ^ s[0], s[6:1]};
    end
  end

  initial begin
    error_count      = 0;
    blocks_in_flight = 0;
  end

  function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] mix_f0(input logic [7:0] v);
    return rol8(v, 1) ^ rol8(v, 2) ^ rol8(v, 7);
  endfunction

  function automatic logic [7:0] mix_f1(input logic [7:0] v);
    return rol8(v, 3) ^ rol8(v, 4) ^ rol8(v, 6);
  endfunction

  function automatic logic [63:0] hight_transform(input logic dec, input logic [63:0] blk,
                                                  input logic [63:0] klo,
                                                  input logic [63:0] khi);
    logic [7:0] mk [16];
    logic [7:0] wk [8];
    logic [7:0] sk [128];
    logic [7:0] x [8];
    logic [7:0] t;
    logic [7:0] f;
    logic [63:0] res;
    for (int i = 0; i < 8; i++) begin
      mk[i]     = klo[8*i +: 8];
      mk[i + 8] = khi[8*i +: 8];
      x[i]      = blk[8*i +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      wk[i]     = mk[i + 12];
      wk[i + 4] = mk[i];
    end
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        sk[16*i + j]     = mk[(j - i) & 7] + delta_tab[16*i + j];
        sk[16*i + j + 8] = mk[((j - i) & 7) + 8] + delta_tab[16*i + j + 8];
      end
    end
    if (!dec) begin
      x[0] += wk[0]; x[2] ^= wk[1]; x[4] += wk[2]; x[6] ^= wk[3];
    end else begin
      x[0] -= wk[4]; x[2] ^= wk[5]; x[4] -= wk[6]; x[6] ^= wk[7];
    end
    for (int k = 0; k < ROUNDS; k++) begin
      int r;
      r = dec ? ROUNDS - 1 - k : k;
      // Decryption undoes the byte rotation before every round but the first one.
      if (dec && k > 0) begin
        t = x[0];
        for (int i = 0; i < 7; i++) x[i] = x[i + 1];
        x[7] = t;
      end
      f = mix_f1(x[0]) ^ sk[4*r];
      x[1] = dec ? x[1] - f : x[1] + f;
      f = mix_f0(x[2]) + sk[4*r + 1];
      x[3] ^= f;
      f = mix_f1(x[4]) ^ sk[4*r + 2];
      x[5] = dec ? x[5] - f : x[5] + f;
      f = mix_f0(x[6]) + sk[4*r + 3];
      x[7] ^= f;
      if (!dec && k < ROUNDS - 1) begin
        t = x[7];
        for (int i = 7; i > 0; i--) x[i] = x[i - 1];
        x[0] = t;
      end
    end
    if (!dec) begin
      x[0] += wk[4]; x[2] ^= wk[5]; x[4] += wk[6]; x[6] ^= wk[7];
    end else begin
      x[0] -= wk[0]; x[2] ^= wk[1]; x[4] -= wk[2]; x[6] ^= wk[3];
    end
    for (int i = 0; i < 8; i++) res[8*i +: 8] = x[i];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    block_txn_t txn;
    if (rst) begin
      key_lo = '0;
      key_hi = '0;
      expected_blocks.delete();
    end else begin
      // Results are checked before this edge's request is queued, so a block
      // can never be matched against itself.
      if (done !== 1'b0) begin
        if (expected_blocks.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transaction: data_out %016h", data_out);
          mismatches++;
        end else begin
          txn = expected_blocks.pop_front();
          if (data_out !== txn.block_out) begin
            if (mismatches < 10)
              $display("data_out mismatch (%s of %016h): expected %016h, got %016h",
                       txn.dec ? "decrypt" : "encrypt", txn.block_in, txn.block_out,
                       data_out);
            mismatches++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        txn.dec       = req_type;
        txn.block_in  = data_in;
        txn.block_out = hight_transform(req_type, data_in, key_lo, key_hi);
        expected_blocks.push_back(txn);
      end
      if (wr_en) begin
        case (reg_index_t'(wr_index))
          REG_KEY_LOW:  key_lo = wr_data;
          REG_KEY_HIGH: key_hi = wr_data;
          default: ;
        endcase
      end
    end
    blocks_in_flight <= expected_blocks.size();
    error_count      <= mismatches;
  end

endmodule

// ----- tb/sv/tb_hight_block_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// tb_hight_block_cipher_unit
// Drives encrypt and decrypt requests into the HIGHT cipher unit under a
// series of keys, with random sender pauses, and leaves result checking to
// hight_block_checker, whose error count decides the verdict.
// ----------------------------------------------------------------------------
module tb_hight_block_cipher_unit;
  import hight_pkg::*;

  // The slowest correct run is roughly 1100 blocks, each with the longest
  // sender pause, plus a pipeline drain per key change. The limit is far above that.
  localparam int LIMIT_CYCLES = 200000;
  // This covers the unit's pipeline depth with margin.
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_BLOCKS = 150;
  localparam int KEY_PHASES   = 7;

  localparam logic [63:0] EDGE_BLOCKS [6] = '{
    64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
    64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
    64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa
  };

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [63:0] data_in;
  logic        done;
  logic [63:0] data_out;
  logic        wr_en;
  logic [0:0]  wr_index;
  logic [63:0] wr_data;
  int          error_count;
  int          blocks_in_flight;
  int          cycle_count = 0;

  hight_block_cipher_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .data_in  (data_in),
    .done     (done),
    .data_out (data_out),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // The checker sees exactly the same pins as the unit and owns all the
  // prediction and comparison; this module only makes stimulus.
  hight_block_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .req_type         (req_type),
    .data_in          (data_in),
    .done             (done),
    .data_out         (data_out),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .error_count      (error_count),
    .blocks_in_flight (blocks_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_hight_block_cipher_unit: errors");
      $finish;
    end
  end

  // Presents one request at the falling edge and holds it until a rising
  // edge sees busy low, which is where the transaction is accepted. start
  // stays high on return so that the next call makes a back-to-back request.
  task automatic send_block(input logic dec, input logic [63:0] blk);
    @(negedge clk);
    start    = 1'b1;
    req_type = dec;
    data_in  = blk;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Sender pause; the payload pins carry noise while start is low.
  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      start    = 1'b0;
      req_type = 1'($urandom_range(0, 1));
      data_in  = {$urandom, $urandom};
    end
  endtask

  // Stops sending and waits on falling edges, where the checker's count is
  // stable, until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (blocks_in_flight != 0) @(negedge clk);
  endtask

  // Key writes only happen with the pipeline empty, so every block in a
  // phase is computed with one known key.
  task automatic write_key(input reg_index_t idx, input logic [63:0] value);
    wait_drained();
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(negedge clk);
    wr_en    = 1'b0;
  endtask

  // Random requests with random operation and content. Pauses come in
  // stretches: every 50 requests the sender decides anew whether it idles.
  task automatic random_phase(input int count, input bit allow_idle);
    bit idle_on;
    idle_on = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) idle_on = allow_idle && ($urandom_range(0, 2) != 0);
      send_block(1'($urandom_range(0, 1)), {$urandom, $urandom});
      if (idle_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  initial begin : stimulus
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    rst      = 1'b1;
    start    = 1'b0;
    req_type = 1'b0;
    data_in  = '0;
    wr_en    = 1'b0;
    wr_index = REG_KEY_LOW;
    wr_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The unit reports busy for a cycle after reset.
    while (busy !== 1'b0) @(negedge clk);

    // Directed part: the edge patterns in both directions, first with the
    // all-zero key left by reset, then with the all-ones key.
    for (int p = 0; p < 6; p++) begin
      send_block(1'b0, EDGE_BLOCKS[p]);
      send_block(1'b1, EDGE_BLOCKS[p]);
    end
    write_key(REG_KEY_LOW, '1);
    write_key(REG_KEY_HIGH, '1);
    for (int p = 0; p < 6; p++) begin
      send_block(1'b0, EDGE_BLOCKS[p]);
      send_block(1'b1, EDGE_BLOCKS[p]);
    end

    // Random part across several keys: the byte-ramp key of the published
    // test vectors, the two half-extreme keys, then random keys. Each key
    // change drains the pipeline first, so the sender waits for all results
    // several times. The last phase runs with no pauses at all.
    for (int p = 0; p < KEY_PHASES; p++) begin
      case (p)
        0: begin
          key_lo = 64'h7766_5544_3322_1100;
          key_hi = 64'hffee_ddcc_bbaa_9988;
        end
        1: begin
          key_lo = '0;
          key_hi = '1;
        end
        2: begin
          key_lo = '1;
          key_hi = '0;
        end
        default: begin
          key_lo = {$urandom, $urandom};
          key_hi = {$urandom, $urandom};
        end
      endcase
      write_key(REG_KEY_LOW, key_lo);
      write_key(REG_KEY_HIGH, key_hi);
      random_phase(PHASE_BLOCKS, p != KEY_PHASES - 1);
    end

    // Let everything come back, then watch a little longer for stray results.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_hight_block_cipher_unit: clean");
    end else begin
      $display("tb_hight_block_cipher_unit: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/hight_pkg.sv
src/hight_key_sched.sv
src/hight_whiten.sv
src/hight_round.sv
src/hight_block_cipher_unit.sv
tb/sv/hight_block_checker.sv
tb/sv/tb_hight_block_cipher_unit.sv
